// ----- rtl/fsp_pkg.sv -----
package fsp_pkg;

    // Width of one base-b digit; the radix register is five bits wide.
    localparam int DIGIT_W = 5;

    localparam int DIM_W  = 5;
    localparam int BASE_W = 5;
    localparam int ND_W   = 6;

    typedef enum logic [1:0] {
        REG_DIMENSIONS  = 2'd0,
        REG_BASE        = 2'd1,
        REG_NUM_DIGITS  = 2'd2,
        REG_SKIP_ENABLE = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POW,
        S_SKIP,
        S_INIT,
        S_DIV,
        S_PUSH,
        S_TAYLOR,
        S_COPY,
        S_CONV,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_TAYLOR,
        OP_COPY,
        OP_CONV
    } line_op_t;

    typedef struct packed {
        line_op_t             op;
        logic                 pass_start;
        logic                 add_en;
        logic [DIGIT_W-1:0]   load_digit;
    } line_ctrl_t;

endpackage

// ----- rtl/fsp_divider.sv -----
module fsp_divider (
    input  logic                          clk,
    input  logic                          init,
    input  logic                          clr,
    input  logic                          step,
    input  logic [32:0]                   dividend,
    input  logic [fsp_pkg::BASE_W-1:0]    divisor,
    output logic [fsp_pkg::DIGIT_W-1:0]   remainder
);

    logic [32:0]                  nq_reg;
    logic [fsp_pkg::DIGIT_W-1:0]  rem_reg;
    logic [fsp_pkg::DIGIT_W:0]    trial;
    logic                         ge;

    // Restoring division, one quotient bit a cycle while step is high; the quotient replaces
    // the dividend so that the next digit divides it again.
    assign trial = {rem_reg, nq_reg[32]};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk)
    begin
        if (init)
        begin
            nq_reg  <= dividend;
            rem_reg <= '0;
        end
        else if (clr)
        begin
            rem_reg <= '0;
        end
        else if (step)
        begin
            nq_reg  <= {nq_reg[31:0], ge};
            rem_reg <= ge ? fsp_pkg::DIGIT_W'(trial - {1'b0, divisor})
                          : trial[fsp_pkg::DIGIT_W-1:0];
        end
    end

    assign remainder = rem_reg;

endmodule

// ----- rtl/fsp_digit_line.sv -----
module fsp_digit_line #(
    parameter int MAX_DIGITS = 32
) (
    input  logic                          clk,
    input  fsp_pkg::line_ctrl_t           ctrl,
    input  logic [fsp_pkg::BASE_W-1:0]    base,
    output logic                          carry_out
);

    localparam int DW = fsp_pkg::DIGIT_W;

    logic [DW-1:0] c_reg [MAX_DIGITS];
    logic [DW-1:0] w_reg [MAX_DIGITS];
    logic [DW-1:0] v_reg;
    logic          carry_reg;

    logic          conv;
    logic [DW-1:0] p;
    logic [DW-1:0] q;
    logic          cin;
    logic [DW:0]   sum;
    logic          ge;
    logic [DW-1:0] mod_sum;
    logic [DW-1:0] taylor_new;

    // Shared modular adder: p + q + cin reduced once, both operands below b.
    assign conv    = ctrl.op == fsp_pkg::OP_CONV;
    assign p       = conv ? w_reg[MAX_DIGITS-1] : c_reg[MAX_DIGITS-1];
    assign q       = conv ? w_reg[MAX_DIGITS-1] : (ctrl.pass_start ? '0 : v_reg);
    assign cin     = conv && !ctrl.pass_start && carry_reg;
    assign sum     = {1'b0, p} + {1'b0, q} + {{DW{1'b0}}, cin};
    assign ge      = sum >= {1'b0, base};
    assign mod_sum = ge ? DW'(sum - {1'b0, base}) : sum[DW-1:0];

    assign taylor_new = ctrl.add_en ? mod_sum : c_reg[MAX_DIGITS-1];
    assign carry_out  = ge;

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            fsp_pkg::OP_LOAD:
            begin
                for (int m = 0; m < MAX_DIGITS - 1; m++)
                begin
                    c_reg[m] <= c_reg[m+1];
                end
                c_reg[MAX_DIGITS-1] <= ctrl.load_digit;
            end
            fsp_pkg::OP_TAYLOR:
            begin
                for (int m = 0; m < MAX_DIGITS - 1; m++)
                begin
                    c_reg[m+1] <= c_reg[m];
                end
                c_reg[0] <= taylor_new;
                v_reg    <= taylor_new;
            end
            fsp_pkg::OP_COPY:
            begin
                for (int m = 0; m < MAX_DIGITS; m++)
                begin
                    w_reg[m] <= c_reg[m];
                end
            end
            fsp_pkg::OP_CONV:
            begin
                for (int m = 0; m < MAX_DIGITS - 1; m++)
                begin
                    w_reg[m+1] <= w_reg[m];
                end
                w_reg[0]  <= mod_sum;
                carry_reg <= ge;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- rtl/faure_sequence_point_unit.sv -----
// From start, the first coordinate follows the optional skip, the digit expansion and the
// bit-serial conversion; each further dimension adds its Taylor passes and a conversion,
// all through the single modular adder.
// One point at a time: busy stays high until the last coordinate beat has been shown.
// Results are strobed for one cycle and the receiver cannot stall them.
// Reset returns the sequencer to idle and the registers to 2, 2, 32 and 0.
module faure_sequence_point_unit #(
    parameter int MAX_DIM    = 16,
    parameter int MAX_DIGITS = 32,
    parameter int COORD_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [31:0]             point_index,
    output logic                    valid,
    output logic [COORD_BITS-1:0]   coordinate,
    output logic [3:0]              dim_index,
    output logic                    last,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int KW  = $clog2(MAX_DIGITS);
    localparam int CBW = $clog2(COORD_BITS);
    localparam int NW  = fsp_pkg::ND_W + 1;
    localparam logic [KW-1:0]  K_TOP  = KW'(MAX_DIGITS - 1);
    localparam logic [CBW-1:0] CB_TOP = CBW'(COORD_BITS - 1);

    logic [fsp_pkg::DIM_W-1:0]  dimensions_reg;
    logic [fsp_pkg::BASE_W-1:0] base_reg;
    logic [fsp_pkg::ND_W-1:0]   num_digits_reg;
    logic                       skip_enable_reg;

    fsp_pkg::state_t state_reg, state_next;
    logic [32:0]               n_reg, n_next;
    logic [2*fsp_pkg::BASE_W-1:0] pow2_reg, pow2_next;
    logic [KW-1:0]             kdig_reg, kdig_next;
    logic [5:0]                bc_reg, bc_next;
    logic [KW-1:0]             i_reg, i_next;
    logic [KW-1:0]             k_reg, k_next;
    logic [CBW-1:0]            cb_reg, cb_next;
    logic [fsp_pkg::DIM_W-1:0] j_reg, j_next;
    logic [COORD_BITS-1:0]     coord_reg, coord_next;

    logic [fsp_pkg::BASE_W-1:0] b;
    logic [NW-1:0]              nd;
    logic [fsp_pkg::DIM_W-1:0]  dcount;
    logic                       cfg_write;

    logic                        div_init;
    logic                        div_clr;
    logic                        div_step;
    logic [fsp_pkg::DIGIT_W-1:0] div_rem;
    fsp_pkg::line_ctrl_t         ctrl;
    logic                        line_carry;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimensions_reg  <= fsp_pkg::DIM_W'(2);
            base_reg        <= fsp_pkg::BASE_W'(2);
            num_digits_reg  <= fsp_pkg::ND_W'(32);
            skip_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (fsp_pkg::cfg_reg_t'(paddr[3:2]))
                fsp_pkg::REG_DIMENSIONS:  dimensions_reg  <= pwdata[fsp_pkg::DIM_W-1:0];
                fsp_pkg::REG_BASE:        base_reg        <= pwdata[fsp_pkg::BASE_W-1:0];
                fsp_pkg::REG_NUM_DIGITS:  num_digits_reg  <= pwdata[fsp_pkg::ND_W-1:0];
                fsp_pkg::REG_SKIP_ENABLE: skip_enable_reg <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (fsp_pkg::cfg_reg_t'(paddr[3:2]))
            fsp_pkg::REG_DIMENSIONS:  prdata = 32'(dimensions_reg);
            fsp_pkg::REG_BASE:        prdata = 32'(base_reg);
            fsp_pkg::REG_NUM_DIGITS:  prdata = 32'(num_digits_reg);
            fsp_pkg::REG_SKIP_ENABLE: prdata = 32'(skip_enable_reg);
            default:                  prdata = '0;
        endcase
    end

    // Effective settings with the out-of-range values folded in.
    always_comb
    begin
        b = (base_reg < fsp_pkg::BASE_W'(2)) ? fsp_pkg::BASE_W'(2) : base_reg;
        if (num_digits_reg == '0)
            nd = NW'(1);
        else if (int'(num_digits_reg) > MAX_DIGITS)
            nd = NW'(MAX_DIGITS);
        else
            nd = NW'(num_digits_reg);
        if (dimensions_reg == '0)
            dcount = fsp_pkg::DIM_W'(1);
        else if (int'(dimensions_reg) > MAX_DIM)
            dcount = fsp_pkg::DIM_W'(MAX_DIM);
        else
            dcount = dimensions_reg;
    end

    fsp_divider u_divider (
        .clk       (clk),
        .init      (div_init),
        .clr       (div_clr),
        .step      (div_step),
        .dividend  (n_reg),
        .divisor   (b),
        .remainder (div_rem)
    );

    fsp_digit_line #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_digit_line (
        .clk       (clk),
        .ctrl      (ctrl),
        .base      (b),
        .carry_out (line_carry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fsp_pkg::S_IDLE;
            kdig_reg  <= '0;
            bc_reg    <= '0;
            i_reg     <= '0;
            k_reg     <= '0;
            cb_reg    <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kdig_reg  <= kdig_next;
            bc_reg    <= bc_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            cb_reg    <= cb_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        pow2_reg  <= pow2_next;
        coord_reg <= coord_next;
    end

    // Sequencer: optional skip offset, digit expansion, then for each dimension a bit-serial
    // conversion of the base-b fraction to binary, preceded from dimension 1 on by a Taylor
    // shift by one (dimension j+1 is dimension j shifted once more).
    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        pow2_next       = pow2_reg;
        kdig_next       = kdig_reg;
        bc_next         = bc_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        cb_next         = cb_reg;
        j_next          = j_reg;
        coord_next      = coord_reg;
        div_init        = 1'b0;
        div_clr         = 1'b0;
        div_step        = 1'b0;
        ctrl.op         = fsp_pkg::OP_HOLD;
        ctrl.pass_start = 1'b0;
        ctrl.add_en     = 1'b0;
        ctrl.load_digit = '0;

        case (state_reg)
            fsp_pkg::S_IDLE:
            begin
                if (start)
                begin
                    n_next     = {1'b0, point_index};
                    state_next = skip_enable_reg ? fsp_pkg::S_POW : fsp_pkg::S_INIT;
                end
            end
            fsp_pkg::S_POW:
            begin
                pow2_next  = b * b;
                state_next = fsp_pkg::S_SKIP;
            end
            fsp_pkg::S_SKIP:
            begin
                n_next     = n_reg + 33'(pow2_reg * pow2_reg) - 33'd1;
                state_next = fsp_pkg::S_INIT;
            end
            fsp_pkg::S_INIT:
            begin
                div_init   = 1'b1;
                bc_next    = '0;
                kdig_next  = '0;
                state_next = fsp_pkg::S_DIV;
            end
            fsp_pkg::S_DIV:
            begin
                div_step = 1'b1;
                bc_next  = bc_reg + 6'd1;
                if (bc_reg == 6'd32)
                    state_next = fsp_pkg::S_PUSH;
            end
            fsp_pkg::S_PUSH:
            begin
                ctrl.op         = fsp_pkg::OP_LOAD;
                ctrl.load_digit = (NW'(kdig_reg) < nd) ? div_rem : '0;
                div_clr         = 1'b1;
                if (kdig_reg == K_TOP)
                begin
                    j_next     = '0;
                    state_next = fsp_pkg::S_COPY;
                end
                else
                begin
                    kdig_next = kdig_reg + KW'(1);
                    if (NW'(kdig_reg) + NW'(1) < nd)
                    begin
                        bc_next    = '0;
                        state_next = fsp_pkg::S_DIV;
                    end
                end
            end
            fsp_pkg::S_TAYLOR:
            begin
                ctrl.op         = fsp_pkg::OP_TAYLOR;
                ctrl.pass_start = k_reg == K_TOP;
                ctrl.add_en     = (k_reg != K_TOP) && (k_reg >= i_reg);
                if (k_reg == '0)
                begin
                    if (NW'(i_reg) == nd - NW'(2))
                    begin
                        state_next = fsp_pkg::S_COPY;
                    end
                    else
                    begin
                        i_next = i_reg + KW'(1);
                        k_next = K_TOP;
                    end
                end
                else
                begin
                    k_next = k_reg - KW'(1);
                end
            end
            fsp_pkg::S_COPY:
            begin
                ctrl.op    = fsp_pkg::OP_COPY;
                coord_next = '0;
                cb_next    = '0;
                k_next     = K_TOP;
                state_next = fsp_pkg::S_CONV;
            end
            fsp_pkg::S_CONV:
            begin
                ctrl.op         = fsp_pkg::OP_CONV;
                ctrl.pass_start = k_reg == K_TOP;
                // The carry out of the leading digit is the next fraction bit.
                if (k_reg == '0)
                begin
                    coord_next = {coord_reg[COORD_BITS-2:0], line_carry};
                    k_next     = K_TOP;
                    if (cb_reg == CB_TOP)
                        state_next = fsp_pkg::S_EMIT;
                    else
                        cb_next = cb_reg + CBW'(1);
                end
                else
                begin
                    k_next = k_reg - KW'(1);
                end
            end
            fsp_pkg::S_EMIT:
            begin
                if (j_reg == dcount - fsp_pkg::DIM_W'(1))
                begin
                    state_next = fsp_pkg::S_IDLE;
                end
                else
                begin
                    j_next = j_reg + fsp_pkg::DIM_W'(1);
                    if (nd == NW'(1))
                    begin
                        state_next = fsp_pkg::S_COPY;
                    end
                    else
                    begin
                        i_next     = '0;
                        k_next     = K_TOP;
                        state_next = fsp_pkg::S_TAYLOR;
                    end
                end
            end
            default:
            begin
                state_next = fsp_pkg::S_IDLE;
            end
        endcase
    end

    assign busy       = state_reg != fsp_pkg::S_IDLE;
    assign valid      = state_reg == fsp_pkg::S_EMIT;
    assign coordinate = coord_reg;
    assign dim_index  = j_reg[3:0];
    assign last       = j_reg == dcount - fsp_pkg::DIM_W'(1);

endmodule

// ----- verif/tb_faure_sequence_point_unit.sv -----
`timescale 1ns / 100ps

module tb_faure_sequence_point_unit;

    typedef struct {
        logic [31:0] coord;
        logic [3:0]  dim;
        logic        fin;
    } coord_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] point_index = '0;
    logic        valid;
    logic [31:0] coordinate;
    logic [3:0]  dim_index;
    logic        last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Register copies used by the coordinate predictor.
    logic [4:0]  dims_reg = 5'd2;
    logic [4:0]  base_reg = 5'd2;
    logic [5:0]  digits_reg = 6'd32;
    logic        skip_reg = 1'b0;

    coord_beat_t pending_coords[$];
    int          error_count = 0;
    int          points_sent = 0;
    int          beats_seen = 0;
    int          settings_used = 0;
    bit          gaps_on = 1'b1;

    faure_sequence_point_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .point_index(point_index), .valid(valid), .coordinate(coordinate),
        .dim_index(dim_index), .last(last), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always #5 clk = ~clk;

    function automatic void predict_point(logic [31:0] idx);
        int unsigned      b, nd, dc, p, s, pw, jm, carry, t;
        longint unsigned  n;
        int unsigned      a[32];
        int unsigned      y[32];
        int unsigned      pas[32][32];
        logic [31:0]      acc;
        coord_beat_t      beat;
        b = (base_reg < 2) ? 2 : 32'(base_reg);
        nd = (digits_reg < 1) ? 1 : ((digits_reg > 32) ? 32 : 32'(digits_reg));
        dc = (dims_reg < 1) ? 1 : ((dims_reg > 16) ? 16 : 32'(dims_reg));
        n = 64'(idx);
        if (skip_reg)
        begin
            p = b * b * b * b;
            n = n + p - 1;
        end
        for (int k = 0; k < nd; k++)
        begin
            a[k] = 32'(n % b);
            n = n / b;
        end
        for (int k = 0; k < nd; k++)
        begin
            pas[k][0] = 1;
            for (int r = 1; r < k; r++)
                pas[k][r] = (pas[k-1][r-1] + pas[k-1][r]) % b;
            pas[k][k] = 1;
        end
        for (int j = 0; j < dc; j++)
        begin
            jm = j % b;
            for (int r = 0; r < nd; r++)
            begin
                s = 0;
                pw = 1;
                for (int k = r; k < nd; k++)
                begin
                    s = (s + pas[k][r] * pw % b * a[k]) % b;
                    pw = pw * jm % b;
                end
                y[r] = s;
            end
            // Exact binary expansion of the base-b fraction by repeated doubling.
            acc = '0;
            for (int i = 0; i < 32; i++)
            begin
                carry = 0;
                for (int r = nd - 1; r >= 0; r--)
                begin
                    t = y[r] * 2 + carry;
                    y[r] = t % b;
                    carry = t / b;
                end
                acc = {acc[30:0], carry[0]};
            end
            beat.coord = acc;
            beat.dim = j[3:0];
            beat.fin = (j + 1 == dc);
            pending_coords.push_back(beat);
        end
    endfunction

    always @(posedge clk)
    begin
        coord_beat_t want;
        if (rst_n && valid)
        begin
            beats_seen++;
            if (pending_coords.size() == 0)
            begin
                $error("coordinate beat with nothing expected: dim %0d coord %h",
                       dim_index, coordinate);
                error_count++;
            end
            else
            begin
                want = pending_coords.pop_front();
                if (coordinate !== want.coord)
                begin
                    $error("coordinate: expected %h, got %h", want.coord, coordinate);
                    error_count++;
                end
                if (dim_index !== want.dim)
                begin
                    $error("dim_index: expected %0d, got %0d", want.dim, dim_index);
                    error_count++;
                end
                if (last !== want.fin)
                begin
                    $error("last: expected %0b, got %0b", want.fin, last);
                    error_count++;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (!gaps_on || r < 10)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic reg_write(fsp_pkg::cfg_reg_t which, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {which, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (pready !== 1'b1)
        begin
            $error("pready: expected 1, got %b", pready);
            error_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // The address is still held, so the read data shows the new value.
        @(posedge clk);
        if (prdata !== value)
        begin
            $error("prdata: expected %h, got %h", value, prdata);
            error_count++;
        end
    endtask

    task automatic configure(logic [4:0] d, logic [4:0] b, logic [5:0] nd, logic sk);
        reg_write(fsp_pkg::REG_DIMENSIONS, {27'd0, d});
        reg_write(fsp_pkg::REG_BASE, {27'd0, b});
        reg_write(fsp_pkg::REG_NUM_DIGITS, {26'd0, nd});
        reg_write(fsp_pkg::REG_SKIP_ENABLE, {31'd0, sk});
        dims_reg = d;
        base_reg = b;
        digits_reg = nd;
        skip_reg = sk;
        settings_used++;
    endtask

    // Start stays high after an accepted point unless the next call idles; an idle
    // gap is counted from the cycle in which the block is free again.
    task automatic send_point(logic [31:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        point_index <= idx;
        do
            @(posedge clk);
        while (busy);
        predict_point(idx);
        points_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_coords.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic test_reset_values();
        send_point(32'd0);
        send_point(32'd1);
        send_point(32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_widest_point();
        configure(5'd16, 5'd17, 6'd32, 1'b1);
        send_point(32'hFFFF_FFFF);
        send_point(32'h8000_0001);
        drain();
    endtask

    task automatic test_register_clamps();
        configure(5'd0, 5'd0, 6'd0, 1'b0);
        send_point(32'd5);
        drain();
        configure(5'd31, 5'd1, 6'd63, 1'b1);
        send_point(32'hA5A5_5A5A);
        drain();
        // Non-prime radix, and more dimensions than the radix.
        configure(5'd5, 5'd4, 6'd6, 1'b0);
        send_point(32'd4095);
        send_point(32'd1234);
        drain();
        configure(5'd6, 5'd3, 6'd4, 1'b1);
        send_point(32'd80);
        send_point(32'd81);
        drain();
        // Too few digits for the index, so it wraps.
        configure(5'd2, 5'd7, 6'd2, 1'b0);
        send_point(32'd48);
        send_point(32'd49);
        send_point(32'd0);
        drain();
    endtask

    task automatic test_random_points();
        logic [4:0] d, b;
        logic [5:0] nd;
        int         pick;
        for (int ph = 0; ph < 10; ph++)
        begin
            d = 5'($urandom_range(1, 3));
            if ($urandom_range(0, 9) == 0)
                d = 5'($urandom_range(0, 31));
            case ($urandom_range(0, 7))
                0: b = 5'd2;
                1: b = 5'd3;
                2: b = 5'd5;
                3: b = 5'd7;
                4: b = 5'd11;
                5: b = 5'd13;
                6: b = 5'd17;
                default: b = 5'($urandom_range(0, 31));
            endcase
            nd = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(1, 10));
            configure(d, b, nd, 1'($urandom_range(0, 1)));
            gaps_on = (ph % 3 != 2);
            for (int i = 0; i < 13; i++)
            begin
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    send_point($urandom_range(0, 300));
                else
                    send_point($urandom());
            end
            drain();
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_widest_point();
        test_register_clamps();
        test_random_points();
        repeat (50) @(posedge clk);
        $display("Covered %0d points and %0d coordinate beats over %0d register settings,",
                 points_sent, beats_seen, settings_used);
        $display("including clamped, non-prime and skipped configurations.");
        if (error_count == 0)
            $display("faure_sequence_point_unit regression: pass");
        else
            $display("faure_sequence_point_unit regression: fail");
        $finish;
    end

    initial
    begin
        #250_000_000;
        $display("faure_sequence_point_unit regression: fail");
        $finish;
    end

endmodule
